// File: rtl/mpsm_pkg.sv
// Shared types and constants for the multi-pattern string matcher.
package mpsm_pkg;

   // Default sizes
   localparam int NUM_PATTERNS_DEF    = 8;
   localparam int MAX_PATTERN_LEN_DEF = 32;
   localparam int MIN_PATTERN_LEN_DEF = 5;

   // Fixed field widths
   localparam int PAT_IDX_W  = 3;
   localparam int CHAR_IDX_W = 5;
   localparam int VALUE_W    = 8;
   localparam int POS_W      = 32;

   // Request codes on req_type
   typedef enum logic [1:0] {
      REQ_CHAR_WR = 2'd0,
      REQ_LEN_WR  = 2'd1,
      REQ_TEXT    = 2'd2,
      REQ_RESTART = 2'd3
   } req_code_type;

   // Per-cycle control broadcast to every cell
   typedef struct packed {
      logic shift;    // take the neighbor's window byte
      logic clear;    // restart: zero the window byte
      logic char_wr;  // pattern character write (column selected in cell)
   } cell_ctl_type;

endpackage

// File: rtl/multi_pattern_string_matcher.sv
// Top level of the multi-pattern exact string matcher.
//
// Request channel (req_*): one beat per load or text item. req_type selects
// a pattern character write, a pattern length write, a text byte or a text
// restart. Loads and restarts give no result.
// Response channel (rsp_*): one beat per match, carrying the pattern index
// and the start offset of the occurrence; rsp_last marks the final match
// caused by a text byte. Matches for one byte come in ascending pattern order.
// A text byte occupies the block from its accept through a read and a compare
// state per pattern slot and a final flush, as the single compare row is shared
// across all pattern slots; req_stall holds further beats until it is done.
// Load and restart beats are taken whenever the block is idle.
// While rsp_stall holds the response register full, the scan holds at the
// next match it finds once another is pending, or at the final flush, and
// req_stall stays high; it goes on when the register drains.
// Reset clears the pattern lengths (all slots disabled), the text window,
// the byte and position counters and the response register. Pattern
// characters are not cleared and must be written before use.
module multi_pattern_string_matcher import mpsm_pkg::*; #(
   parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
   parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
   parameter int MIN_PATTERN_LEN = MIN_PATTERN_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [PAT_IDX_W-1:0]  req_pattern_index,
   input  logic [CHAR_IDX_W-1:0] req_char_index,
   input  logic [VALUE_W-1:0]    req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PAT_IDX_W-1:0]  rsp_match_pattern,
   output logic [POS_W-1:0]      rsp_start_position,
   output logic                  rsp_last
);

   localparam int PAT_AW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
   localparam int WIN_AW = $clog2(MAX_PATTERN_LEN);

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CHECK, ST_FLUSH} state_type;

   state_type            state_ff, state_in;
   logic [PAT_AW-1:0]    scan_ff, scan_in;
   logic [LEN_W-1:0]     len_ff [NUM_PATTERNS];
   logic [LEN_W-1:0]     len_wr_value;
   logic [LEN_W-1:0]     cur_len_ff, cur_len_in;
   logic [LEN_W-1:0]     seen_ff, seen_in;
   logic [POS_W-1:0]     pos_ff, pos_in;

   logic                 pend_valid_ff, pend_valid_in;
   logic [PAT_IDX_W-1:0] pend_pat_ff, pend_pat_in;
   logic [POS_W-1:0]     pend_start_ff, pend_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PAT_IDX_W-1:0] rsp_pat_ff, rsp_pat_in;
   logic [POS_W-1:0]     rsp_start_ff, rsp_start_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 accept, pidx_ok, cidx_ok;
   logic [31:0]          pidx_ext, scan_ext;
   logic [PAT_AW-1:0]    wr_addr;
   cell_ctl_type         cell_ctl;
   logic [VALUE_W-1:0]   win [MAX_PATTERN_LEN];
   logic [MAX_PATTERN_LEN-1:0] hits;
   logic                 len_ok, match, out_free, scan_done;
   logic [POS_W-1:0]     match_start;
   logic [PAT_IDX_W-1:0] match_pat;

   // ---------------- request decode ----------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign pidx_ext  = 32'(req_pattern_index);
   assign wr_addr   = pidx_ext[PAT_AW-1:0];
   assign pidx_ok   = pidx_ext < NUM_PATTERNS;
   assign cidx_ok   = 32'(req_char_index) < MAX_PATTERN_LEN;

   assign cell_ctl.char_wr = accept && (req_type == REQ_CHAR_WR) && pidx_ok && cidx_ok;
   assign cell_ctl.shift   = accept && (req_type == REQ_TEXT);
   assign cell_ctl.clear   = accept && (req_type == REQ_RESTART);

   // lengths above the maximum saturate
   assign len_wr_value = (32'(req_value) > MAX_PATTERN_LEN) ?
                         LEN_W'(MAX_PATTERN_LEN) : LEN_W'(req_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PATTERNS; i++) begin
            len_ff[i] <= '0;
         end
      end else if (accept && (req_type == REQ_LEN_WR) && pidx_ok) begin
         len_ff[wr_addr] <= len_wr_value;
      end
   end

   // ---------------- text counters ----------------
   always_comb begin
      seen_in = seen_ff;
      pos_in  = pos_ff;
      if (cell_ctl.clear) begin
         seen_in = '0;
         pos_in  = '0;
      end else if (cell_ctl.shift) begin
         if (seen_ff != LEN_W'(MAX_PATTERN_LEN)) begin
            seen_in = LEN_W'(seen_ff + 1'b1);
         end
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         pos_ff  <= '0;
      end else begin
         seen_ff <= seen_in;
         pos_ff  <= pos_in;
      end
   end

   // length of the slot under scan, aligned with the cells' read data
   assign cur_len_in = len_ff[scan_ff];
   always_ff @(posedge clock) begin
      cur_len_ff <= cur_len_in;
   end

   // ---------------- cell row ----------------
   // Cell j holds window byte j (j beats ago) and pattern column j. Pattern
   // character j lines up with the byte taken len-1-j beats ago.
   for (genvar j = 0; j < MAX_PATTERN_LEN; j++) begin : g_cell
      logic [VALUE_W-1:0] shift_src;
      logic [LEN_W-1:0]   diff;
      logic               col_en;

      if (j == 0) begin : g_head
         assign shift_src = req_value;
      end else begin : g_body
         assign shift_src = win[j-1];
      end

      assign diff   = cur_len_ff - LEN_W'(j) - LEN_W'(1);
      assign col_en = LEN_W'(j) < cur_len_ff;

      mpsm_cell #(
         .NUM_PATTERNS (NUM_PATTERNS),
         .CELL_INDEX   (j)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .char_index  (req_char_index),
         .wr_addr     (wr_addr),
         .wr_data     (req_value),
         .rd_addr     (scan_ff),
         .shift_data  (shift_src),
         .window_byte (win[j]),
         .cmp_en      (col_en),
         .cmp_byte    (win[diff[WIN_AW-1:0]]),
         .hit         (hits[j])
      );
   end

   // ---------------- match decision ----------------
   assign len_ok      = (32'(cur_len_ff) >= MIN_PATTERN_LEN) && (cur_len_ff <= seen_ff);
   assign match       = len_ok && (&hits);
   assign match_start = pos_ff - 32'(cur_len_ff);
   assign scan_ext    = 32'(scan_ff);
   assign match_pat   = scan_ext[PAT_IDX_W-1:0];
   assign scan_done   = (scan_ff == PAT_AW'(NUM_PATTERNS - 1));
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // ---------------- scan sequencer ----------------
   // A found match is held as pending until the next one (or the end of the
   // scan) tells whether it is the last for this byte.
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      pend_pat_in   = pend_pat_ff;
      pend_start_in = pend_start_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_pat_in    = rsp_pat_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_TEXT)) begin
               state_in = ST_READ;
               scan_in  = '0;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!(match && pend_valid_ff && !out_free)) begin
               if (match) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_pat_in   = pend_pat_ff;
                     rsp_start_in = pend_start_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_pat_in   = match_pat;
                  pend_start_in = match_start;
               end
               if (scan_done) begin
                  state_in = ST_FLUSH;
               end else begin
                  scan_in  = PAT_AW'(scan_ff + 1'b1);
                  state_in = ST_READ;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pat_in    = pend_pat_ff;
               rsp_start_in  = pend_start_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      pend_pat_ff   <= pend_pat_in;
      pend_start_ff <= pend_start_in;
      rsp_pat_ff    <= rsp_pat_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_pattern  = rsp_pat_ff;
   assign rsp_start_position = rsp_start_ff;
   assign rsp_last           = rsp_last_ff;

   // ---------------- assertions ----------------
   // nothing may stay pending once the scan has finished
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending match left over in idle");

   // a text beat starts the scan at the first slot
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_type == REQ_TEXT))
      |=> (state_ff == ST_READ) && (scan_ff == '0))
      else $error("text beat did not start a scan");

   // the flush of a pending match sends it out flagged last
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && pend_valid_ff && out_free)
      |=> rsp_valid_ff && rsp_last_ff && (state_ff == ST_IDLE))
      else $error("final match not flagged last");

endmodule

// File: rtl/mpsm_cell.sv
// One matcher cell: a window byte, one pattern column and its comparator.
module mpsm_cell import mpsm_pkg::*; #(
   parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
   parameter int CELL_INDEX   = 0,
   localparam int PAT_AW      = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [CHAR_IDX_W-1:0] char_index,
   input  logic [PAT_AW-1:0]     wr_addr,
   input  logic [VALUE_W-1:0]    wr_data,
   input  logic [PAT_AW-1:0]     rd_addr,
   input  logic [VALUE_W-1:0]    shift_data,
   output logic [VALUE_W-1:0]    window_byte,
   input  logic                  cmp_en,
   input  logic [VALUE_W-1:0]    cmp_byte,
   output logic                  hit
);

   // column of pattern characters at this position, one per pattern
   logic [VALUE_W-1:0] col_mem [NUM_PATTERNS];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [VALUE_W-1:0] window_ff, window_in;

   always_ff @(posedge clock) begin
      if (ctl.char_wr && (32'(char_index) == CELL_INDEX)) begin
         col_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= col_mem[rd_addr];
   end

   always_comb begin
      window_in = window_ff;
      if (ctl.clear) begin
         window_in = '0;
      end else if (ctl.shift) begin
         window_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   assign window_byte = window_ff;
   // positions past the pattern's end always agree
   assign hit = !cmp_en || (rd_data_ff == cmp_byte);

endmodule

// File: tb/sv/multi_pattern_string_matcher_tb.sv
// Self-checking testbench for the multi-pattern string matcher.
`timescale 1ns / 100ps

module multi_pattern_string_matcher_tb;
   import mpsm_pkg::*;

   localparam int NUM_PAT      = NUM_PATTERNS_DEF;
   localparam int MAX_LEN      = MAX_PATTERN_LEN_DEF;
   localparam int MIN_LEN      = MIN_PATTERN_LEN_DEF;
   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_CYCLES  = 300;
   // time allowed for stray responses after the last expected match
   localparam int DRAIN_CYCLES = 4 * (2 * NUM_PAT + 2);
   localparam int LIMIT_NS     = 3_000_000;
   localparam int MAX_PRINTS   = 100;

   // one match as seen on the response channel
   typedef struct packed {
      logic [PAT_IDX_W-1:0] slot;
      logic [POS_W-1:0]     offset;
      logic                 last;
   } match_type;

   // per-beat note: typed=1 means the matches below are hand-written and
   // replace what the predictor works out for that beat
   typedef struct packed {
      logic       typed;
      logic [1:0] count;
      match_type  first;
      match_type  second;
   } beat_note_type;

   typedef struct packed {
      req_code_type          kind;
      logic [PAT_IDX_W-1:0]  slot;
      logic [CHAR_IDX_W-1:0] column;
      logic [VALUE_W-1:0]    value;
      beat_note_type         note;
   } stim_row_type;

   localparam beat_note_type PREDICTED = '0;
   localparam beat_note_type NO_MATCH  = '{1'b1, 2'd0, '0, '0};

   // Directed opening. Pattern 0 and pattern 7 are both five zero bytes;
   // pattern 0 first gets a length below the minimum so it must stay silent.
   localparam int DIRECTED_ROWS = 28;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // nothing is enabled right after reset
      '{REQ_TEXT,    3'd0, 5'd0,  8'hFF, NO_MATCH},
      '{REQ_CHAR_WR, 3'd0, 5'd0,  8'h00, PREDICTED},
      '{REQ_CHAR_WR, 3'd0, 5'd1,  8'h00, PREDICTED},
      '{REQ_CHAR_WR, 3'd0, 5'd2,  8'h00, PREDICTED},
      '{REQ_CHAR_WR, 3'd0, 5'd3,  8'h00, PREDICTED},
      '{REQ_CHAR_WR, 3'd0, 5'd4,  8'h00, PREDICTED},
      '{REQ_LEN_WR,  3'd0, 5'd0,  8'd4,  PREDICTED},
      '{REQ_CHAR_WR, 3'd7, 5'd0,  8'h00, PREDICTED},
      '{REQ_CHAR_WR, 3'd7, 5'd1,  8'h00, PREDICTED},
      '{REQ_CHAR_WR, 3'd7, 5'd2,  8'h00, PREDICTED},
      '{REQ_CHAR_WR, 3'd7, 5'd3,  8'h00, PREDICTED},
      '{REQ_CHAR_WR, 3'd7, 5'd4,  8'h00, PREDICTED},
      // top column, never read since the length stays short
      '{REQ_CHAR_WR, 3'd7, 5'd31, 8'hFF, PREDICTED},
      '{REQ_LEN_WR,  3'd7, 5'd0,  8'd5,  PREDICTED},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, PREDICTED},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, PREDICTED},
      // three zeros in a row: the too-short pattern 0 would hit on the next one
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, NO_MATCH},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, PREDICTED},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, '{1'b1, 2'd1, '{3'd7, 32'd1, 1'b1}, '0}},
      '{REQ_LEN_WR,  3'd0, 5'd0,  8'd5,  PREDICTED},
      // restart: the cleared window is all zeros, yet nothing may match early
      '{REQ_RESTART, 3'd0, 5'd0,  8'h00, PREDICTED},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, NO_MATCH},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, NO_MATCH},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, NO_MATCH},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, NO_MATCH},
      // two patterns end on one byte: ascending slot order, last on the second
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00,
        '{1'b1, 2'd2, '{3'd0, 32'd0, 1'b0}, '{3'd7, 32'd0, 1'b1}}},
      '{REQ_LEN_WR,  3'd7, 5'd0,  8'd0,  PREDICTED},
      '{REQ_TEXT,    3'd0, 5'd0,  8'h00, '{1'b1, 2'd1, '{3'd0, 32'd1, 1'b1}, '0}}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_code_type          req_type;
   logic [PAT_IDX_W-1:0]  req_pattern_index;
   logic [CHAR_IDX_W-1:0] req_char_index;
   logic [VALUE_W-1:0]    req_value;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PAT_IDX_W-1:0]  rsp_match_pattern;
   logic [POS_W-1:0]      rsp_start_position;
   logic                  rsp_last;

   multi_pattern_string_matcher u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_pattern_index  (req_pattern_index),
      .req_char_index     (req_char_index),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_match_pattern  (rsp_match_pattern),
      .rsp_start_position (rsp_start_position),
      .rsp_last           (rsp_last)
   );

   // ---------------------------------------------------------------
   // Shadow of the matcher: pattern store, lengths, text window and
   // counters, advanced on every accepted request beat.
   // ---------------------------------------------------------------
   bit [7:0]  shadow_chars [NUM_PAT][MAX_LEN];
   int        shadow_len   [NUM_PAT];
   bit [7:0]  shadow_window [MAX_LEN];   // [0] is the newest byte
   int        shadow_fill;               // bytes since restart, saturating
   bit [31:0] shadow_pos;                // bytes since restart, wrapping

   match_type     beat_matches [$];      // matches caused by the current beat
   match_type     pending_matches [$];   // expected, not yet seen on rsp_*
   beat_note_type beat_notes [$];        // one per driven request beat
   int            mismatch_count;

   // Stimulus-side view of what has been loaded, known when a beat is
   // built. Used to keep every enabled pattern fully written and to plant
   // pattern occurrences in the text.
   bit [7:0]         known_chars  [NUM_PAT][MAX_LEN];
   int               known_len    [NUM_PAT];
   bit [MAX_LEN-1:0] written_mask [NUM_PAT];

   int beats_sent;
   bit tx_calm;
   bit rx_calm;
   bit hold_pending;

   // Works out the matches that one request beat causes.
   function automatic void scan_beat(input req_code_type kind,
                                     input logic [PAT_IDX_W-1:0] slot,
                                     input logic [CHAR_IDX_W-1:0] column,
                                     input logic [VALUE_W-1:0] value);
      int        k;
      int        q;
      int        j;
      int        len;
      bit        hit;
      match_type m;
      beat_matches.delete();
      case (kind)
         REQ_CHAR_WR: shadow_chars[slot][column] = value;
         REQ_LEN_WR:  shadow_len[slot] = (value > MAX_LEN) ? MAX_LEN : int'(value);
         REQ_RESTART: begin
            for (k = 0; k < MAX_LEN; k++) shadow_window[k] = 8'h00;
            shadow_fill = 0;
            shadow_pos  = '0;
         end
         default: begin
            for (k = MAX_LEN - 1; k > 0; k--) shadow_window[k] = shadow_window[k-1];
            shadow_window[0] = value;
            if (shadow_fill < MAX_LEN) shadow_fill++;
            shadow_pos++;
            for (q = 0; q < NUM_PAT; q++) begin
               len = shadow_len[q];
               if (len < MIN_LEN || len > shadow_fill) continue;
               hit = 1'b1;
               // pattern char j sits len-1-j bytes back in the window
               for (j = 0; j < len; j++) begin
                  if (shadow_chars[q][j] != shadow_window[len-1-j]) hit = 1'b0;
               end
               if (hit) begin
                  m.slot   = PAT_IDX_W'(q);
                  m.offset = shadow_pos - POS_W'(len);
                  m.last   = 1'b0;
                  beat_matches = {beat_matches, m};
               end
            end
            if (beat_matches.size() > 0) beat_matches[beat_matches.size()-1].last = 1'b1;
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      // keep the log bounded when the block is badly off
      if (mismatch_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_match();
      match_type want;
      if (pending_matches.size() == 0) begin
         flag_mismatch($sformatf("match slot %0d offset %0d with none expected",
                                 rsp_match_pattern, rsp_start_position));
         return;
      end
      want = pending_matches.pop_front();
      if (rsp_match_pattern !== want.slot)
         flag_mismatch($sformatf("match_pattern %0d, want %0d",
                                 rsp_match_pattern, want.slot));
      if (rsp_start_position !== want.offset)
         flag_mismatch($sformatf("start_position %0d, want %0d (slot %0d)",
                                 rsp_start_position, want.offset, want.slot));
      if (rsp_last !== want.last)
         flag_mismatch($sformatf("last %b, want %b (slot %0d)",
                                 rsp_last, want.last, want.slot));
   endtask

   // Both channels are sampled at the rising edge; inputs move only on the
   // falling edge, so every value seen here is settled.
   always @(posedge clock) begin
      beat_note_type note;
      if (!reset) begin
         // a result can never belong to a beat taken at the same edge
         if (rsp_valid && !rsp_stall) check_match();
         if (req_valid && !req_stall) begin
            scan_beat(req_type, req_pattern_index, req_char_index, req_value);
            note = beat_notes.pop_front();
            if (note.typed) begin
               beat_matches.delete();
               if (note.count >= 2'd1) beat_matches = {beat_matches, note.first};
               if (note.count >= 2'd2) beat_matches = {beat_matches, note.second};
            end
            foreach (beat_matches[i]) pending_matches = {pending_matches, beat_matches[i]};
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   // Mostly a two-letter alphabet so random text hits often.
   function automatic logic [7:0] pick_symbol();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, 1) ? 8'h61 : 8'h62;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Number of pattern chars written from column 0 up without a hole.
   function automatic int loaded_prefix(input int slot);
      int n;
      n = 0;
      while (n < MAX_LEN && written_mask[slot][n]) n++;
      return n;
   endfunction

   // Drives one request beat, starting and ending on a falling edge.
   // The payload holds still until the beat is taken.
   task automatic send_beat(input req_code_type kind,
                            input logic [PAT_IDX_W-1:0] slot,
                            input logic [CHAR_IDX_W-1:0] column,
                            input logic [VALUE_W-1:0] value,
                            input beat_note_type note);
      int gap;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (kind == REQ_CHAR_WR) begin
         known_chars[slot][column]  = value;
         written_mask[slot][column] = 1'b1;
      end else if (kind == REQ_LEN_WR) begin
         known_len[slot] = (value > MAX_LEN) ? MAX_LEN : int'(value);
      end
      beat_notes = {beat_notes, note};
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_pattern_index <= slot;
      req_char_index    <= column;
      req_value         <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_text(input logic [7:0] value);
      send_beat(REQ_TEXT, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                value, PREDICTED);
   endtask

   // Full pattern load: chars from column 0 up, then the length.
   // Now and then the length beat is dropped, leaving a partly rewritten
   // pattern live under its old length.
   task automatic load_pattern();
      int         slot;
      int         len;
      int         r;
      int         j;
      logic [7:0] len_value;
      slot = $urandom_range(0, NUM_PAT - 1);
      r = $urandom_range(0, 19);
      if (r == 0)     len = MAX_LEN;
      else if (r < 3) len = $urandom_range(9, MAX_LEN - 1);
      else if (r < 5) len = $urandom_range(1, MIN_LEN - 1);
      else            len = $urandom_range(MIN_LEN, 8);
      for (j = 0; j < len; j++)
         send_beat(REQ_CHAR_WR, 3'(slot), 5'(j), pick_symbol(), PREDICTED);
      len_value = 8'(len);
      // oversized lengths saturate to the window size
      if (len == MAX_LEN && $urandom_range(0, 1)) len_value = 8'($urandom_range(MAX_LEN, 255));
      if ($urandom_range(0, 7) != 0)
         send_beat(REQ_LEN_WR, 3'(slot), 5'($urandom_range(0, 31)), len_value, PREDICTED);
   endtask

   // Single stray writes: any char anywhere, or a length that only covers
   // chars already written (including zero to disable).
   task automatic poke_store();
      int         slot;
      int         prefix;
      logic [7:0] len_value;
      slot = $urandom_range(0, NUM_PAT - 1);
      if ($urandom_range(0, 1)) begin
         send_beat(REQ_CHAR_WR, 3'(slot), 5'($urandom_range(0, 31)),
                   8'($urandom_range(0, 255)), PREDICTED);
      end else begin
         prefix = loaded_prefix(slot);
         len_value = 8'($urandom_range(0, prefix));
         if (prefix == MAX_LEN && $urandom_range(0, 1))
            len_value = 8'($urandom_range(MAX_LEN, 255));
         send_beat(REQ_LEN_WR, 3'(slot), 5'($urandom_range(0, 31)), len_value, PREDICTED);
      end
   endtask

   // Text run with live patterns planted in it, whole or cut short.
   task automatic text_burst();
      int total;
      int n;
      int slot;
      int cut;
      int j;
      total = $urandom_range(8, 40);
      n = 0;
      while (n < total) begin
         slot = $urandom_range(0, NUM_PAT - 1);
         if ($urandom_range(0, 99) < 30 && known_len[slot] >= MIN_LEN) begin
            cut = $urandom_range(0, 3) ? known_len[slot] : $urandom_range(1, known_len[slot]);
            for (j = 0; j < cut; j++) send_text(known_chars[slot][j]);
            n += cut;
         end else begin
            send_text(pick_symbol());
            n++;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Clock, limit, receiver
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // Response side: random stalls, short mostly, long sometimes, none at
   // all in calm phases. On request it holds stall for a long stretch so
   // the block backs up into the request channel.
   initial begin : rsp_side
      int stall_left;
      int r;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (rx_calm) begin
            rsp_stall <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_stall <= 1'b0;
            end else begin
               stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(9, 29);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Main sequence: reset, directed table, random mix, drain, verdict
   // ---------------------------------------------------------------
   initial begin : stim_main
      int i;
      int pick;
      int next_hold;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_type          = REQ_TEXT;
      req_pattern_index = '0;
      req_char_index    = '0;
      req_value         = '0;
      tx_calm           = 1'b0;
      rx_calm           = 1'b0;
      hold_pending      = 1'b0;
      mismatch_count    = 0;
      beats_sent        = 0;
      shadow_fill       = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         send_beat(DIRECTED[i].kind, DIRECTED[i].slot, DIRECTED[i].column,
                   DIRECTED[i].value, DIRECTED[i].note);

      // random part: mostly text runs over loaded patterns, with loads,
      // stray writes and restarts mixed in
      next_hold = beats_sent;
      while (beats_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         tx_calm = ($urandom_range(0, 5) == 0);
         rx_calm = ($urandom_range(0, 5) == 0);
         if (beats_sent >= next_hold) begin
            hold_pending = 1'b1;
            next_hold += 200;
         end
         pick = $urandom_range(0, 99);
         if (pick < 18)      load_pattern();
         else if (pick < 24) poke_store();
         else if (pick < 28) send_beat(REQ_RESTART, 3'($urandom_range(0, 7)),
                                       5'($urandom_range(0, 31)),
                                       8'($urandom_range(0, 255)), PREDICTED);
         else                text_burst();
      end
      req_valid <= 1'b0;

      while (pending_matches.size() != 0) @(posedge clock);
      // any stray beat after this point is flagged by the monitor
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
